// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the IMAP string parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked on every clk_i edge, off while rst_ni is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every clk_i edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/imapsl_pkg.sv =====
// Types, codes and character constants of the IMAP string parser.
package imapsl_pkg;

  localparam int unsigned LengthBitsDefault = 32;
  localparam logic [31:0] MaxLenReset       = 32'd65536;

  // Parser phases
  typedef enum logic [2:0] {
    PH_SCAN   = 3'd0,
    PH_QUOTED = 3'd1,
    PH_LEN    = 3'd2,
    PH_CR     = 3'd3,
    PH_LF     = 3'd4,
    PH_BODY   = 3'd5,
    PH_DONE   = 3'd6,
    PH_BAD    = 3'd7
  } phase_e;

  // Reported status
  typedef enum logic [1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_COMPLETE   = 2'd1,
    ST_INVALID    = 2'd2
  } status_e;

  // Reported string kind
  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_QUOTED  = 2'd1,
    KIND_LITERAL = 2'd2,
    KIND_NONSYNC = 2'd3
  } kind_e;

  // Character codes
  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChRbrace = 8'h7D;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  // Narrow control state handed between parser step and state registers
  typedef struct packed {
    phase_e phase;
    logic   nonsync;
    logic   digit;
    kind_e  kind;
  } ctrl_t;

endpackage

// ===== rtl/core/imap_string_literal_parser.sv =====
// Top level of the byte-serial IMAP quoted/literal string parser.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+--------------------------------
//   in      | input     | in_valid_i / in_stall_o   | restart_i, in_byte_i
//   out     | output    | out_valid_o / out_stall_i | content_*, parse_status_o,
//           |           |                           | string_kind_o, body_count_o
//   cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_data_i (max_literal_length)
//
// One byte per cycle while the output is not stalled: each accepted beat is handled by the
// combinational parser step logic, and its result sits in the output register the next cycle.
// Reset puts the parser in the scan phase and the length limit at 65536.
// A stalled result holds; a new input beat is taken whenever the output
// register is empty or is being drained in the same cycle.
`include "assert_macros.svh"

module imap_string_literal_parser #(
  parameter int unsigned LENGTH_BITS = imapsl_pkg::LengthBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  // input beats
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        restart_i,
  input  logic [7:0]  in_byte_i,
  // result beats
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        content_valid_o,
  output logic [7:0]  content_byte_o,
  output logic [1:0]  parse_status_o,
  output logic [1:0]  string_kind_o,
  output logic [31:0] body_count_o
);

  imapsl_pkg::ctrl_t      ctrl_q, ctrl_d;
  logic [LENGTH_BITS-1:0] target_q, target_d;
  logic [31:0]            count_q, count_d;
  logic [31:0]            max_len_q;
  logic                   out_valid_q;
  logic                   cv_q, cv_d;
  logic [7:0]             cb_q, cb_d;
  logic                   in_accept;

  // Config register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= imapsl_pkg::MaxLenReset;
    end else if (cfg_valid_i) begin
      max_len_q <= cfg_data_i;
    end
  end

  // Handshake: take a beat when the output register is free or draining
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  imapsl_step #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_step (
    .ctrl_i    (ctrl_q),
    .target_i  (target_q),
    .count_i   (count_q),
    .max_len_i (max_len_q),
    .restart_i (restart_i),
    .byte_i    (in_byte_i),
    .ctrl_o    (ctrl_d),
    .target_o  (target_d),
    .count_o   (count_d),
    .cv_o      (cv_d),
    .cb_o      (cb_d)
  );

  // Parser state, updated only by accepted beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q.phase   <= imapsl_pkg::PH_SCAN;
      ctrl_q.nonsync <= 1'b0;
      ctrl_q.digit   <= 1'b0;
      ctrl_q.kind    <= imapsl_pkg::KIND_NONE;
      target_q       <= '0;
      count_q        <= '0;
    end else if (in_accept) begin
      ctrl_q   <= ctrl_d;
      target_q <= target_d;
      count_q  <= count_d;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Body byte of the result
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cv_q <= cv_d;
      cb_q <= cb_d;
    end
  end

  // State registers only move on accepted beats, so they match the held result
  assign out_valid_o     = out_valid_q;
  assign content_valid_o = cv_q;
  assign content_byte_o  = cb_q;
  assign string_kind_o   = ctrl_q.kind;
  assign body_count_o    = count_q;

  always_comb begin
    case (ctrl_q.phase)
      imapsl_pkg::PH_DONE: parse_status_o = imapsl_pkg::ST_COMPLETE;
      imapsl_pkg::PH_BAD:  parse_status_o = imapsl_pkg::ST_INVALID;
      default:             parse_status_o = imapsl_pkg::ST_INCOMPLETE;
    endcase
  end

  // Checks
  `ASSERT_ALWAYS(a_stall_needs_result, in_stall_o |-> out_valid_q, "stall without held result")
  `ASSERT_CLK(a_body_has_kind,
    (out_valid_q && cv_q) |-> (ctrl_q.kind != imapsl_pkg::KIND_NONE),
    "body byte with no string kind")
  `ASSERT_CLK(a_invalid_no_body,
    (out_valid_q && ctrl_q.phase == imapsl_pkg::PH_BAD) |-> !cv_q,
    "body byte on invalid string")
  `ASSERT_CLK(a_final_holds,
    (in_accept && !restart_i &&
     (ctrl_q.phase == imapsl_pkg::PH_DONE || ctrl_q.phase == imapsl_pkg::PH_BAD))
    |=> $stable(ctrl_q.phase),
    "final status left without restart")

endmodule

// ===== rtl/core/imapsl_step.sv =====
// One-byte parser step: next parser state and body output from current state.
module imapsl_step #(
  parameter int unsigned LENGTH_BITS = imapsl_pkg::LengthBitsDefault
) (
  input  imapsl_pkg::ctrl_t       ctrl_i,
  input  logic [LENGTH_BITS-1:0]  target_i,
  input  logic [31:0]             count_i,
  input  logic [31:0]             max_len_i,
  input  logic                    restart_i,
  input  logic [7:0]              byte_i,
  output imapsl_pkg::ctrl_t       ctrl_o,
  output logic [LENGTH_BITS-1:0]  target_o,
  output logic [31:0]             count_o,
  output logic                    cv_o,
  output logic [7:0]              cb_o
);

  localparam int unsigned LW = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;
  localparam int unsigned AW = LENGTH_BITS + 4;

  imapsl_pkg::ctrl_t      ctrl;
  logic [LENGTH_BITS-1:0] target;
  logic [31:0]            count;
  logic [31:0]            count_inc;

  logic [LW-1:0]          max_w;
  logic [LW-1:0]          cap_w;
  logic [LW-1:0]          lim_w;
  logic [AW-1:0]          lim_a;
  logic [AW-1:0]          acc;
  logic                   is_digit;

  // Restart clears the parser before this byte
  always_comb begin
    if (restart_i) begin
      ctrl.phase   = imapsl_pkg::PH_SCAN;
      ctrl.nonsync = 1'b0;
      ctrl.digit   = 1'b0;
      ctrl.kind    = imapsl_pkg::KIND_NONE;
      target       = '0;
      count        = '0;
    end else begin
      ctrl   = ctrl_i;
      target = target_i;
      count  = count_i;
    end
  end

  assign count_inc = count + 32'd1;

  // Length limit clipped to what the target register holds
  assign max_w = LW'(max_len_i);
  assign cap_w = LW'({LENGTH_BITS{1'b1}});
  assign lim_w = (max_w < cap_w) ? max_w : cap_w;
  assign lim_a = AW'(lim_w[LENGTH_BITS-1:0]);

  // target*10 + digit; target never exceeds the limit so AW bits suffice
  assign acc = {target, 3'b000} + AW'({target, 1'b0}) + AW'(byte_i[3:0]);

  assign is_digit = (byte_i inside {[imapsl_pkg::ChZero:imapsl_pkg::ChNine]});

  // Phase transitions
  always_comb begin
    ctrl_o   = ctrl;
    target_o = target;
    count_o  = count;
    cv_o     = 1'b0;
    cb_o     = 8'h00;
    case (ctrl.phase)
      imapsl_pkg::PH_SCAN: begin
        if (byte_i == imapsl_pkg::ChLbrace) begin
          ctrl_o.phase = imapsl_pkg::PH_LEN;
        end else if (byte_i == imapsl_pkg::ChQuote) begin
          ctrl_o.phase = imapsl_pkg::PH_QUOTED;
          ctrl_o.kind  = imapsl_pkg::KIND_QUOTED;
        end
      end
      imapsl_pkg::PH_QUOTED: begin
        if (byte_i == imapsl_pkg::ChQuote) begin
          ctrl_o.phase = imapsl_pkg::PH_DONE;
        end else begin
          cv_o = 1'b1;
          cb_o = byte_i;
          // saturating count
          if (count != 32'hFFFF_FFFF) count_o = count_inc;
        end
      end
      imapsl_pkg::PH_LEN: begin
        if (is_digit && !ctrl.nonsync) begin
          if (acc > lim_a) begin
            ctrl_o.phase = imapsl_pkg::PH_BAD;
          end else begin
            target_o     = acc[LENGTH_BITS-1:0];
            ctrl_o.digit = 1'b1;
          end
        end else if (byte_i == imapsl_pkg::ChPlus && !ctrl.nonsync && ctrl.digit) begin
          ctrl_o.nonsync = 1'b1;
        end else if (byte_i == imapsl_pkg::ChRbrace && ctrl.digit) begin
          ctrl_o.kind  = ctrl.nonsync ? imapsl_pkg::KIND_NONSYNC : imapsl_pkg::KIND_LITERAL;
          ctrl_o.phase = imapsl_pkg::PH_CR;
        end else begin
          ctrl_o.phase = imapsl_pkg::PH_BAD;
        end
      end
      imapsl_pkg::PH_CR: begin
        ctrl_o.phase = (byte_i == imapsl_pkg::ChCr) ? imapsl_pkg::PH_LF : imapsl_pkg::PH_BAD;
      end
      imapsl_pkg::PH_LF: begin
        if (byte_i != imapsl_pkg::ChLf) begin
          ctrl_o.phase = imapsl_pkg::PH_BAD;
        end else if (target == '0) begin
          ctrl_o.phase = imapsl_pkg::PH_DONE;
        end else begin
          ctrl_o.phase = imapsl_pkg::PH_BODY;
        end
      end
      imapsl_pkg::PH_BODY: begin
        cv_o    = 1'b1;
        cb_o    = byte_i;
        count_o = count_inc;
        if (LW'(count_inc) >= LW'(target)) ctrl_o.phase = imapsl_pkg::PH_DONE;
      end
      default: begin
        // complete or invalid: hold until restart
      end
    endcase
  end

endmodule
